// File: rtl/tte_pkg.sv
// Shared types and constants for the text terminal cursor engine.
// No dependencies; tte_rem, tte_seq and the core module import this package.
package tte_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_LINES   = 64;

   localparam int COL_AW = $clog2(MAX_COLUMNS);
   localparam int ROW_AW = $clog2(MAX_LINES);
   localparam int ADDR_W = ROW_AW + COL_AW;
   localparam int DEPTH  = MAX_COLUMNS * MAX_LINES;

   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int COL_W      = 8;
   localparam int ROW_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // remainder unit: dividend below 2*MAX_LINES, one restoring step per cycle
   localparam int REM_DW    = ROW_AW + 1;
   localparam int REM_STEPS = ROW_AW + 1;
   localparam int REM_SW    = $clog2(REM_STEPS);
   localparam int REM_TW    = ROW_W + ROW_AW;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   localparam logic [CSR_IDX_W-1:0] REG_LINE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL       = 2'd2;

   localparam logic [ROW_W-1:0] LINE_COUNT_RST   = 7'd24;
   localparam logic [COL_W-1:0] COLUMN_COUNT_RST = 8'd80;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT,
      CMD_SET,
      CMD_CLEAR,
      CMD_READ
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCROLL,
      ST_CHAR,
      ST_REM,
      ST_FILL,
      ST_WRITE,
      ST_READ,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      JOB_SCROLL,
      JOB_WRITE,
      JOB_READ
   } job_type;

   // clamped configuration
   typedef struct packed {
      logic [ROW_W-1:0] lines;
      logic [COL_W-1:0] cols;
      logic             scroll;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [REM_DW-1:0] dividend;
      logic [ROW_W-1:0]  divisor;
   } rem_req_type;

   typedef struct packed {
      logic              done;
      logic [ROW_AW-1:0] remainder;
   } rem_rsp_type;

endpackage

// File: rtl/tte_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tte_rem.sv
// Iterative remainder unit: dividend mod line count, one compare-subtract per cycle.
// Depends on tte_pkg.
module tte_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  tte_pkg::rem_req_type rem_req,
   output tte_pkg::rem_rsp_type rem_rsp
);

   import tte_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_SW-1:0] step_ff, step_in;
   logic [REM_DW-1:0] rem_ff, rem_in;
   logic [ROW_W-1:0]  div_ff, div_in;
   logic [REM_TW-1:0] trial;
   logic              fits;

   assign trial = REM_TW'(div_ff) << step_ff;
   assign fits  = REM_TW'(rem_ff) >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (rem_req.start) begin
         rem_in  = rem_req.dividend;
         div_in  = rem_req.divisor;
         step_in = REM_SW'(REM_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - trial[REM_DW-1:0];
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = rem_ff[ROW_AW-1:0];

endmodule

// File: rtl/tte_seq.sv
// Command sequencer: cursor, top line, row valid bits, scroll and row fill.
// Depends on tte_pkg; drives tte_rem and the cell RAM.
module tte_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  tte_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tte_pkg::CMD_W-1:0]      req_command,
   input  logic [tte_pkg::CHAR_W-1:0]     req_character,
   input  logic                           req_wrap_on,
   input  logic [tte_pkg::COL_W-1:0]      req_column,
   input  logic [tte_pkg::ROW_W-1:0]      req_row,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic [tte_pkg::COL_W-1:0]      rsp_cursor_column,
   output logic [tte_pkg::ROW_W-1:0]      rsp_cursor_row,
   output logic [tte_pkg::CHAR_W-1:0]     rsp_read_char,
   output tte_pkg::rem_req_type           rem_req,
   input  tte_pkg::rem_rsp_type           rem_rsp,
   output logic                           ram_wr_en,
   output logic [tte_pkg::ADDR_W-1:0]     ram_wr_addr,
   output logic [tte_pkg::CHAR_W-1:0]     ram_wr_data,
   output logic                           ram_rd_en,
   output logic [tte_pkg::ADDR_W-1:0]     ram_rd_addr,
   input  logic [tte_pkg::CHAR_W-1:0]     ram_rd_data
);

   import tte_pkg::*;

   state_type            state_ff, state_in;
   job_type              job_ff, job_in;
   logic [CHAR_W-1:0]    ch_ff, ch_in;
   logic                 wrap_ff, wrap_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [COL_W-1:0]     cx_ff, cx_in;
   logic [ROW_W-1:0]     cy_ff, cy_in;
   logic [ROW_AW-1:0]    top_ff, top_in;
   logic [ROW_AW-1:0]    phys_ff, phys_in;
   logic [COL_AW-1:0]    fill_ff, fill_in;
   logic                 second_ff, second_in;
   logic                 ok_ff, ok_in;
   logic [CHAR_W-1:0]    rd_ff, rd_in;
   logic [MAX_LINES-1:0] row_valid_ff, row_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [COL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;

   logic [COL_W-1:0]     sat_x, set_x, cx_inc;
   logic [ROW_W-1:0]     sat_y, set_y;
   logic [ROW_W-1:0]     top_next;
   logic [CHAR_W-1:0]    char_data;
   logic [REM_DW-1:0]    sum_row, sum_cy;
   logic                 read_ok;

   assign sat_x     = (cx_ff > cfg.cols) ? cfg.cols : cx_ff;
   assign sat_y     = (cy_ff > cfg.lines) ? cfg.lines : cy_ff;
   assign set_x     = (req_column > cfg.cols) ? cfg.cols : req_column;
   assign set_y     = (req_row > cfg.lines) ? cfg.lines : req_row;
   assign read_ok   = (req_column < cfg.cols) && (req_row < cfg.lines);
   assign cx_inc    = cx_ff + 1'b1;
   assign top_next  = ROW_W'(rem_rsp.remainder) + 1'b1;
   assign char_data = (ch_ff == CH_BACKSPACE) ? CH_SPACE : ch_ff;
   assign sum_row   = REM_DW'(top_ff) + REM_DW'(req_row[ROW_AW-1:0]);
   assign sum_cy    = REM_DW'(top_ff) + REM_DW'(cy_ff[ROW_AW-1:0]);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      ch_in        = ch_ff;
      wrap_in      = wrap_ff;
      col_in       = col_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      top_in       = top_ff;
      phys_in      = phys_ff;
      fill_in      = fill_ff;
      second_in    = second_ff;
      ok_in        = ok_ff;
      rd_in        = rd_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_char_in  = rsp_char_ff;
      req_ready    = 1'b0;
      rem_req      = '0;
      rem_req.divisor = cfg.lines;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = {phys_ff, fill_ff};
      ram_wr_data  = CH_SPACE;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {rem_rsp.remainder, col_ff[COL_AW-1:0]};

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ch_in     = req_character;
               wrap_in   = req_wrap_on;
               col_in    = req_column;
               cx_in     = sat_x;
               cy_in     = sat_y;
               ok_in     = 1'b1;
               rd_in     = '0;
               second_in = 1'b0;
               case (cmd_type'(req_command))
                  CMD_PUT: begin
                     state_in = ST_SCROLL;
                  end
                  CMD_SET: begin
                     cx_in    = set_x;
                     cy_in    = set_y;
                     state_in = ST_DONE;
                  end
                  CMD_CLEAR: begin
                     row_valid_in = '0;
                     top_in       = '0;
                     state_in     = ST_DONE;
                  end
                  CMD_READ: begin
                     if (read_ok) begin
                        rem_req.start    = 1'b1;
                        rem_req.dividend = sum_row;
                        job_in           = JOB_READ;
                        state_in         = ST_REM;
                     end else begin
                        ok_in    = 1'b0;
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            if (cy_ff >= cfg.lines) begin
               if (!cfg.scroll) begin
                  ok_in    = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  rem_req.start    = 1'b1;
                  rem_req.dividend = REM_DW'(top_ff);
                  job_in           = JOB_SCROLL;
                  state_in         = ST_REM;
               end
            end else if (second_ff) begin
               rem_req.start    = 1'b1;
               rem_req.dividend = sum_cy;
               job_in           = JOB_WRITE;
               state_in         = ST_REM;
            end else begin
               state_in = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (ch_ff == CH_NEWLINE) begin
               cx_in    = '0;
               cy_in    = cy_ff + 1'b1;
               state_in = ST_DONE;
            end else if (ch_ff == CH_BACKSPACE) begin
               if (cx_ff == '0) begin
                  ok_in    = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  cx_in            = cx_ff - 1'b1;
                  rem_req.start    = 1'b1;
                  rem_req.dividend = sum_cy;
                  job_in           = JOB_WRITE;
                  state_in         = ST_REM;
               end
            end else if (cx_ff >= cfg.cols) begin
               if (!wrap_ff) begin
                  ok_in    = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  cx_in     = '0;
                  cy_in     = cy_ff + 1'b1;
                  second_in = 1'b1;
                  state_in  = ST_SCROLL;
               end
            end else begin
               rem_req.start    = 1'b1;
               rem_req.dividend = sum_cy;
               job_in           = JOB_WRITE;
               state_in         = ST_REM;
            end
         end
         ST_REM: begin
            if (rem_rsp.done) begin
               phys_in = rem_rsp.remainder;
               case (job_ff)
                  JOB_SCROLL: begin
                     row_valid_in[rem_rsp.remainder] = 1'b0;
                     top_in   = (top_next == cfg.lines) ? '0 : top_next[ROW_AW-1:0];
                     cy_in    = cy_ff - 1'b1;
                     state_in = ST_SCROLL;
                  end
                  JOB_WRITE: begin
                     if (row_valid_ff[rem_rsp.remainder]) begin
                        state_in = ST_WRITE;
                     end else begin
                        fill_in  = '0;
                        state_in = ST_FILL;
                     end
                  end
                  JOB_READ: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            // blank a row on its first write after a scroll or clear
            ram_wr_en = 1'b1;
            fill_in   = fill_ff + 1'b1;
            if (fill_ff == COL_AW'(MAX_COLUMNS - 1)) begin
               row_valid_in[phys_ff] = 1'b1;
               state_in              = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {phys_ff, cx_ff[COL_AW-1:0]};
            ram_wr_data = char_data;
            if (ch_ff != CH_BACKSPACE) begin
               if ((cx_inc == cfg.cols) && wrap_ff) begin
                  cx_in = '0;
                  cy_in = cy_ff + 1'b1;
               end else begin
                  cx_in = cx_inc;
               end
            end
            state_in = ST_DONE;
         end
         ST_READ: begin
            rd_in    = row_valid_ff[phys_ff] ? ram_rd_data : CH_SPACE;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_col_in   = cx_ff;
               rsp_row_in   = cy_ff;
               rsp_char_in  = rd_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cx_ff        <= '0;
         cy_ff        <= '0;
         top_ff       <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         top_ff       <= top_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      ch_ff       <= ch_in;
      wrap_ff     <= wrap_in;
      col_ff      <= col_in;
      phys_ff     <= phys_in;
      fill_ff     <= fill_in;
      second_ff   <= second_in;
      ok_ff       <= ok_in;
      rd_ff       <= rd_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_ok_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_read_char     = rsp_char_ff;

endmodule

// File: rtl/text_terminal_cursor_engine_core.sv
// Top level of the text terminal cursor engine: config registers and unit wiring.
// Depends on tte_pkg, tte_ram, tte_rem and tte_seq.
//
// Usage:
//   req_* carries one request (put character, set cursor, clear, read cell);
//   it is taken when req_valid and req_ready are high at a clock edge.
//   rsp_* returns one result per request, held until rsp_ready.
//   csr_wr_en writes line count, column count or scroll enable by csr_index.
// Work per request (accept to rsp_valid):
//   set cursor, clear, refused read: answered with no pass of the remainder unit.
//   read cell: a pass of the 7-step remainder unit
//   that maps a screen row to a store row, then a cell read.
//   put character: each scroll adds another pass of the remainder unit,
//   and the first write into a row after reset, a scroll or a clear
//   first blanks every column of that row.
// One request is worked on at a time; req_ready is high only when idle.
// A finished result waits in the output register while the next request is
// taken; a second result waits until the receiver takes the first.
// Reset clears the cursor, top line and row valid bits: every
// row reads as spaces with no clearing pass. Config returns to 24 x 80.
module text_terminal_cursor_engine_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tte_pkg::CMD_W-1:0]          req_command,
   input  logic [tte_pkg::CHAR_W-1:0]         req_character,
   input  logic                               req_wrap_on,
   input  logic [tte_pkg::COL_W-1:0]          req_column,
   input  logic [tte_pkg::ROW_W-1:0]          req_row,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_accepted,
   output logic [tte_pkg::COL_W-1:0]          rsp_cursor_column,
   output logic [tte_pkg::ROW_W-1:0]          rsp_cursor_row,
   output logic [tte_pkg::CHAR_W-1:0]         rsp_read_char,
   input  logic                               csr_wr_en,
   input  logic [tte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tte_pkg::CSR_DATA_W-1:0]     csr_data
);

   import tte_pkg::*;

   logic [ROW_W-1:0]  line_count_ff, line_count_in;
   logic [COL_W-1:0]  column_count_ff, column_count_in;
   logic              scroll_ff, scroll_in;
   cfg_type           cfg;
   rem_req_type       rem_req;
   rem_rsp_type       rem_rsp;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CHAR_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CHAR_W-1:0] ram_rd_data;

   always_comb begin
      line_count_in   = line_count_ff;
      column_count_in = column_count_ff;
      scroll_in       = scroll_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_LINE_COUNT:   line_count_in   = csr_data[ROW_W-1:0];
            REG_COLUMN_COUNT: column_count_in = csr_data[COL_W-1:0];
            REG_SCROLL:       scroll_in       = csr_data[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff   <= LINE_COUNT_RST;
         column_count_ff <= COLUMN_COUNT_RST;
         scroll_ff       <= 1'b1;
      end else begin
         line_count_ff   <= line_count_in;
         column_count_ff <= column_count_in;
         scroll_ff       <= scroll_in;
      end
   end

   always_comb begin
      if (line_count_ff == '0) begin
         cfg.lines = ROW_W'(1);
      end else if (line_count_ff > ROW_W'(MAX_LINES)) begin
         cfg.lines = ROW_W'(MAX_LINES);
      end else begin
         cfg.lines = line_count_ff;
      end
      if (column_count_ff == '0) begin
         cfg.cols = COL_W'(1);
      end else if (column_count_ff > COL_W'(MAX_COLUMNS)) begin
         cfg.cols = COL_W'(MAX_COLUMNS);
      end else begin
         cfg.cols = column_count_ff;
      end
      cfg.scroll = scroll_ff;
   end

   tte_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tte_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   tte_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_character     (req_character),
      .req_wrap_on       (req_wrap_on),
      .req_column        (req_column),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_read_char     (rsp_read_char),
      .rem_req           (rem_req),
      .rem_rsp           (rem_rsp),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous request in progress");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !req_ready)
      else $error("cell write while idle");

   a_read_then_busy: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> !req_ready)
      else $error("read data not consumed before idle");

   a_refused_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_read_char == '0)
      else $error("refused request returns a character");
`endif

endmodule
